// File: rtl/g2j_pkg.sv
// ----------------------------------------------------------------------------
// g2j_pkg
// Types, constants and tables shared by the Gregorian to Jalali date pipeline.
// ----------------------------------------------------------------------------
package g2j_pkg;

	typedef struct packed {
		logic [11:0] greg_year;
		logic [3:0]  greg_month;
		logic [4:0]  greg_day;
	} greg_date_t;

	typedef struct packed {
		logic [11:0] jal_year;
		logic [3:0]  jal_month;
		logic [4:0]  jal_day;
	} jal_date_t;

	localparam int unsigned DaysW = 22;
	typedef logic signed [DaysW-1:0] day_cnt_t;

	localparam int unsigned GregBaseYear     = 1600;
	localparam int unsigned JalOffsetDays    = 79;
	localparam int unsigned JalCycleDays     = 12053;
	localparam int unsigned JalQuadDays      = 1461;
	localparam int unsigned JalBaseYear      = 979;
	localparam int unsigned JalFirstYearDays = 366;
	localparam int unsigned YearDays         = 365;

	// reciprocals: x/100 = (x*Recip100) >> Shift100 for x < 43699
	localparam int unsigned Recip100   = 5243;
	localparam int unsigned Shift100   = 19;
	// floor(2^k/d); estimate is q or q-1, corrected afterwards
	localparam int unsigned ShiftCycle = 27;
	localparam int unsigned RecipCycle = (1 << ShiftCycle) / JalCycleDays;
	localparam int unsigned ShiftQuad  = 20;
	localparam int unsigned RecipQuad  = (1 << ShiftQuad) / JalQuadDays;

	localparam int unsigned JalMonths = 12;

	function automatic logic [8:0] days_before_month(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			default:    d = 9'd365;
		endcase
		return d;
	endfunction

	// first day (0-based) of each Jalali month within the year
	function automatic logic [8:0] jal_month_start(input logic [3:0] idx);
		logic [8:0] d;
		unique case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd62;
			4'd3:    d = 9'd93;
			4'd4:    d = 9'd124;
			4'd5:    d = 9'd155;
			4'd6:    d = 9'd186;
			4'd7:    d = 9'd216;
			4'd8:    d = 9'd246;
			4'd9:    d = 9'd276;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd336;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/gregorian_to_jalali_date_unit.sv
// ----------------------------------------------------------------------------
// gregorian_to_jalali_date_unit
// Converts a Gregorian year/month/day item into the Jalali year/month/day.
//
// Channels: greg (greg_valid/greg_ready) carries one date per item; jal
// (jal_valid/jal_ready) returns exactly one converted date per input item,
// in order. An item moves on any edge where its valid and ready are high.
// Pipeline: eight register stages; a result is presented on jal from the last
// of them.
// Throughput: one item per cycle while jal_ready does not stall the output,
// set by the eight-stage pipeline in which the 33-year cycle and 4-year group
// divisions are each a reciprocal multiply stage and a compare-and-correct stage.
// Reset (arst_n low) clears every stage valid bit; in-flight items are dropped.
// Stall: with jal_ready low the output holds; upstream stages keep moving
// into empty slots, and greg_ready falls only once every stage is occupied.
// Input dates are not checked; odd month or day codes go through the same
// arithmetic and give wrapped results.
// ----------------------------------------------------------------------------
module gregorian_to_jalali_date_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                greg_valid,
	output logic                greg_ready,
	input  g2j_pkg::greg_date_t greg,
	output logic                jal_valid,
	input  logic                jal_ready,
	output g2j_pkg::jal_date_t  jal
);

	logic              days_valid, days_ready;
	g2j_pkg::day_cnt_t days;

	logic en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage 3
	logic [19:0] mag3;
	logic [33:0] prod3;
	logic [6:0]  qe_s3;
	logic [19:0] mag_s3;
	logic        neg_s3;

	// stage 4
	logic [19:0]       r4;
	logic              ge4;
	logic [6:0]        q4;
	logic [13:0]       rr4;
	logic signed [7:0] cyc4;
	logic [13:0]       rr_s4;
	logic              neg_s4;
	logic signed [7:0] cyc_s4;

	// stage 5
	logic [23:0]       prod5;
	logic [3:0]        qe_s5;
	logic [13:0]       rr_s5;
	logic              neg_s5;
	logic signed [7:0] cyc_s5;

	// stage 6
	logic [13:0]        r6;
	logic               ge6;
	logic [3:0]         q6;
	logic [10:0]        r6c;
	logic signed [4:0]  q6s;
	logic signed [12:0] cyc33;
	logic signed [12:0] quad4;
	logic signed [11:0] d3;
	logic [11:0]        jy6;
	logic signed [11:0] d3_s6;
	logic [11:0]        jy_s6;

	// stage 7
	logic               big7;
	logic [10:0]        e7;
	logic [1:0]         y7;
	logic [10:0]        r7;
	logic signed [11:0] d4;
	logic signed [11:0] d4_s7;
	logic [11:0]        jy_s7;

	// stage 8
	logic [3:0]         idx8;
	logic signed [11:0] dd8;
	g2j_pkg::jal_date_t res8;
	g2j_pkg::jal_date_t jal_s8;

	g2j_day_count u_day_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.greg_valid (greg_valid),
		.greg_ready (greg_ready),
		.greg       (greg),
		.days_valid (days_valid),
		.days_ready (days_ready),
		.days       (days)
	);

	assign en_s8      = !v_s8 || jal_ready;
	assign en_s7      = !v_s7 || en_s8;
	assign en_s6      = !v_s6 || en_s7;
	assign en_s5      = !v_s5 || en_s6;
	assign en_s4      = !v_s4 || en_s5;
	assign en_s3      = !v_s3 || en_s4;
	assign days_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= days_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// stage 3: 33-year cycle quotient estimate on the magnitude
	always_comb begin
		mag3  = days[g2j_pkg::DaysW-1] ? 20'(-days) : days[19:0];
		prod3 = 34'(mag3) * 34'(g2j_pkg::RecipCycle);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			qe_s3  <= prod3[33:27];
			mag_s3 <= mag3;
			neg_s3 <= days[g2j_pkg::DaysW-1];
		end
	end

	// stage 4: correct quotient, truncating signed cycle count
	always_comb begin
		r4   = mag_s3 - 20'(qe_s3) * 20'(g2j_pkg::JalCycleDays);
		ge4  = (r4 >= 20'(g2j_pkg::JalCycleDays));
		q4   = qe_s3 + 7'(ge4);
		rr4  = ge4 ? 14'(r4 - 20'(g2j_pkg::JalCycleDays)) : r4[13:0];
		cyc4 = neg_s3 ? -$signed({1'b0, q4}) : $signed({1'b0, q4});
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rr_s4  <= rr4;
			neg_s4 <= neg_s3;
			cyc_s4 <= cyc4;
		end
	end

	// stage 5: 4-year group quotient estimate
	assign prod5 = 24'(rr_s4) * 24'(g2j_pkg::RecipQuad);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			qe_s5  <= prod5[23:20];
			rr_s5  <= rr_s4;
			neg_s5 <= neg_s4;
			cyc_s5 <= cyc_s4;
		end
	end

	// stage 6: correct group quotient, assemble year so far (mod 2^12)
	always_comb begin
		r6    = rr_s5 - 14'(qe_s5) * 14'(g2j_pkg::JalQuadDays);
		ge6   = (r6 >= 14'(g2j_pkg::JalQuadDays));
		q6    = qe_s5 + 4'(ge6);
		r6c   = ge6 ? 11'(r6 - 14'(g2j_pkg::JalQuadDays)) : r6[10:0];
		q6s   = neg_s5 ? -$signed({1'b0, q6}) : $signed({1'b0, q6});
		d3    = neg_s5 ? -$signed({1'b0, r6c}) : $signed({1'b0, r6c});
		cyc33 = 13'(cyc_s5) * 13'sd33;
		quad4 = 13'(q6s) * 13'sd4;
		jy6   = 12'(g2j_pkg::JalBaseYear) + cyc33[11:0] + quad4[11:0];
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			d3_s6 <= d3;
			jy_s6 <= jy6;
		end
	end

	// stage 7: single years after the 366-day first year
	always_comb begin
		big7 = (d3_s6 >= 12'sd366);
		e7   = d3_s6[10:0] - 11'd1;
		if (e7 >= 11'd1095) begin
			y7 = 2'd3;
		end else if (e7 >= 11'd730) begin
			y7 = 2'd2;
		end else if (e7 >= 11'd365) begin
			y7 = 2'd1;
		end else begin
			y7 = 2'd0;
		end
		r7 = e7 - 11'(y7) * 11'd365;
		d4 = big7 ? $signed({1'b0, r7}) : d3_s6;
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			d4_s7 <= d4;
			jy_s7 <= big7 ? jy_s6 + 12'(y7) : jy_s6;
		end
	end

	// stage 8: month walk over cumulative month starts
	always_comb begin
		idx8 = 4'd0;
		for (int k = 1; k < g2j_pkg::JalMonths; k++) begin
			if (d4_s7 >= $signed({3'b0, g2j_pkg::jal_month_start(4'(k))})) begin
				idx8 = 4'(k);
			end
		end
		dd8 = d4_s7 - $signed({3'b0, g2j_pkg::jal_month_start(idx8)}) + 12'sd1;
		res8.jal_year  = jy_s7;
		res8.jal_month = idx8 + 4'd1;
		res8.jal_day   = dd8[4:0];
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			jal_s8 <= res8;
		end
	end

	assign jal_valid = v_s8;
	assign jal       = jal_s8;

endmodule

// File: rtl/g2j_day_count.sv
// ----------------------------------------------------------------------------
// g2j_day_count
// Two-stage pipeline: Gregorian date to signed day count relative to the
// Jalali epoch (days since 1600 with leap rules, less the 79-day offset).
// ----------------------------------------------------------------------------
module g2j_day_count (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                greg_valid,
	output logic                greg_ready,
	input  g2j_pkg::greg_date_t greg,
	output logic                days_valid,
	input  logic                days_ready,
	output g2j_pkg::day_cnt_t   days
);

	logic en_s1, en_s2;
	logic v_s1, v_s2;

	// stage 1
	logic signed [12:0] gy, a3, a99, a399;
	logic [11:0]        m3, m99, m399;
	logic signed [10:0] t4;
	logic [24:0]        p99, py;
	logic [22:0]        p399;
	g2j_pkg::day_cnt_t  gy_ext, d365;

	logic signed [10:0] t4_s1;
	logic               neg99_s1, neg399_s1;
	logic [24:0]        p99_s1, py_s1;
	logic [22:0]        p399_s1;
	g2j_pkg::day_cnt_t  d365_s1;
	logic [11:0]        year_s1;
	logic [3:0]         month_s1;
	logic [4:0]         day_s1;

	// stage 2
	logic [5:0]         q99, yq;
	logic [3:0]         q400;
	logic signed [7:0]  t100;
	logic signed [4:0]  t400;
	logic               div100, div400, leap, add_leap;
	g2j_pkg::day_cnt_t  sum;
	g2j_pkg::day_cnt_t  days_s2;

	assign en_s2      = !v_s2 || days_ready;
	assign en_s1      = !v_s1 || en_s2;
	assign greg_ready = en_s1;

	always_comb begin
		gy   = $signed({1'b0, greg.greg_year}) - 13'sd1600;
		a3   = gy + 13'sd3;
		a99  = gy + 13'sd99;
		a399 = gy + 13'sd399;
		m3   = a3[12] ? 12'(-a3) : a3[11:0];
		m99  = a99[12] ? 12'(-a99) : a99[11:0];
		m399 = a399[12] ? 12'(-a399) : a399[11:0];
		t4   = a3[12] ? -$signed({1'b0, m3[11:2]}) : $signed({1'b0, m3[11:2]});
		p99  = 25'(m99) * 25'(g2j_pkg::Recip100);
		p399 = 23'(m399[11:2]) * 23'(g2j_pkg::Recip100);
		py   = 25'(greg.greg_year) * 25'(g2j_pkg::Recip100);
		gy_ext = g2j_pkg::day_cnt_t'(gy);
		d365   = gy_ext * 22'sd365;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= greg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			t4_s1     <= t4;
			neg99_s1  <= a99[12];
			neg399_s1 <= a399[12];
			p99_s1    <= p99;
			p399_s1   <= p399;
			py_s1     <= py;
			d365_s1   <= d365;
			year_s1   <= greg.greg_year;
			month_s1  <= greg.greg_month;
			day_s1    <= greg.greg_day;
		end
	end

	always_comb begin
		q99  = p99_s1[24:19];
		q400 = p399_s1[22:19];
		yq   = py_s1[24:19];
		t100 = neg99_s1 ? -$signed({2'b0, q99}) : $signed({2'b0, q99});
		t400 = neg399_s1 ? -$signed({1'b0, q400}) : $signed({1'b0, q400});
		// leap tests on the raw year: 1600 is a multiple of 400
		div100   = ({1'b0, year_s1} == 13'(yq) * 13'd100);
		div400   = div100 && (yq[1:0] == 2'b00);
		leap     = ((year_s1[1:0] == 2'b00) && !div100) || div400;
		add_leap = leap && (month_s1 >= 4'd3);
		sum = d365_s1
			+ g2j_pkg::day_cnt_t'(t4_s1)
			- g2j_pkg::day_cnt_t'(t100)
			+ g2j_pkg::day_cnt_t'(t400)
			+ $signed({13'b0, g2j_pkg::days_before_month(month_s1)})
			+ $signed({21'b0, add_leap})
			+ $signed({17'b0, day_s1})
			- 22'sd1
			- 22'(g2j_pkg::JalOffsetDays);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			days_s2 <= sum;
		end
	end

	assign days_valid = v_s2;
	assign days       = days_s2;

endmodule

// File: verif/jalali_date_checker.sv
// ----------------------------------------------------------------------------
// jalali_date_checker
// Watches both channels of the date unit, converts each accepted Gregorian
// date to its Jalali form and compares every returned item against it, in order.
// ----------------------------------------------------------------------------
module jalali_date_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                greg_valid,
	input  logic                greg_ready,
	input  g2j_pkg::greg_date_t greg,
	input  logic                jal_valid,
	input  logic                jal_ready,
	input  g2j_pkg::jal_date_t  jal,
	output int unsigned         mismatches,
	output int unsigned         pending,
	output int unsigned         compared
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint BaseYear      = 1600;
	localparam longint EpochShift    = 79;
	localparam longint CycleDays     = 12053;
	localparam longint QuadDays      = 1461;
	localparam longint FirstJalYear  = 979;
	localparam longint LongYearDays  = 366;
	localparam longint ShortYearDays = 365;

	g2j_pkg::jal_date_t jalali_due[$];
	g2j_pkg::jal_date_t want;

	function automatic g2j_pkg::jal_date_t jalali_from_gregorian(input g2j_pkg::greg_date_t g);
		longint             gy;
		longint             gd;
		longint             days;
		longint             jy;
		int                 i;
		g2j_pkg::jal_date_t r;
		gy = g.greg_year;
		gy = gy - BaseYear;
		gd = g.greg_day;
		days = ShortYearDays * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
		case (g.greg_month)
			4'd0, 4'd1: days += 0;
			4'd2:       days += 31;
			4'd3:       days += 59;
			4'd4:       days += 90;
			4'd5:       days += 120;
			4'd6:       days += 151;
			4'd7:       days += 181;
			4'd8:       days += 212;
			4'd9:       days += 243;
			4'd10:      days += 273;
			4'd11:      days += 304;
			4'd12:      days += 334;
			default:    days += 365;
		endcase
		if (g.greg_month >= 4'd3 && ((gy % 4 == 0 && gy % 100 != 0) || gy % 400 == 0))
			days += 1;
		days = days + gd - 1 - EpochShift;
		jy = FirstJalYear + 33 * (days / CycleDays);
		days = days % CycleDays;
		jy = jy + 4 * (days / QuadDays);
		days = days % QuadDays;
		if (days >= LongYearDays) begin
			jy = jy + (days - 1) / ShortYearDays;
			days = (days - 1) % ShortYearDays;
		end
		i = 0;
		while (i < 11 && days >= ((i < 6) ? 31 : 30)) begin
			days = days - ((i < 6) ? 31 : 30);
			i++;
		end
		days = days + 1;
		r.jal_year  = jy[11:0];
		r.jal_month = 4'(i + 1);
		r.jal_day   = days[4:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, exp_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jalali_due.delete();
			pending <= 0;
			mismatches = 0;
			compared = 0;
		end else begin
			if (jal_valid && jal_ready) begin
				if (jalali_due.size() == 0) begin
					report("item with nothing pending", 32'(jal), 0);
				end else begin
					want = jalali_due.pop_front();
					compared++;
					if (jal.jal_year !== want.jal_year)
						report("jal_year", jal.jal_year, want.jal_year);
					if (jal.jal_month !== want.jal_month)
						report("jal_month", jal.jal_month, want.jal_month);
					if (jal.jal_day !== want.jal_day)
						report("jal_day", jal.jal_day, want.jal_day);
				end
			end
			if (greg_valid && greg_ready)
				jalali_due.push_back(jalali_from_gregorian(greg));
			pending <= jalali_due.size();
		end
	end

endmodule

// File: verif/gregorian_to_jalali_date_unit_test.sv
// ----------------------------------------------------------------------------
// gregorian_to_jalali_date_unit_test
// Drives dates into the Gregorian to Jalali unit under changing idle mixes and
// a long output stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module gregorian_to_jalali_date_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 3000;
	localparam int HoldCycles = 300;
	localparam int PhaseItems = 160;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                greg_valid = 1'b0;
	logic                greg_ready;
	g2j_pkg::greg_date_t greg = '0;
	logic                jal_valid;
	logic                jal_ready = 1'b0;
	g2j_pkg::jal_date_t  jal;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned compared;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_token = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned dates_sent = 0;

	gregorian_to_jalali_date_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.greg_valid (greg_valid),
		.greg_ready (greg_ready),
		.greg       (greg),
		.jal_valid  (jal_valid),
		.jal_ready  (jal_ready),
		.jal        (jal)
	);

	jalali_date_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.greg_valid (greg_valid),
		.greg_ready (greg_ready),
		.greg       (greg),
		.jal_valid  (jal_valid),
		.jal_ready  (jal_ready),
		.jal        (jal),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				jal_ready <= 1'b0;
			end else begin
				jal_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (greg_valid && greg_ready) || (jal_valid && jal_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d);
		if (send_idle_pct != 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				greg_valid <= 1'b0;
				@(negedge clk);
			end
		end
		greg_valid <= 1'b1;
		greg       <= g2j_pkg::greg_date_t'{greg_year: y, greg_month: m, greg_day: d};
		do @(posedge clk); while (!greg_ready);
		dates_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_dates(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 80)
				send_date(12'($urandom_range(4095, 1601)), 4'($urandom_range(12, 1)),
					5'($urandom_range(31, 1)));
			else
				send_date(12'($urandom_range(4095, 0)), 4'($urandom_range(15, 0)),
					5'($urandom_range(31, 0)));
		end
	endtask

	task automatic wait_drained();
		greg_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 76;
		send_date(12'd1601, 4'd1, 5'd1);
		send_date(12'd4095, 4'd12, 5'd31);
		send_date(12'd2000, 4'd2, 5'd29);
		send_date(12'd2000, 4'd3, 5'd1);
		send_date(12'd1900, 4'd2, 5'd28);
		send_date(12'd1900, 4'd3, 5'd1);
		send_date(12'd2024, 4'd3, 5'd20);
		send_date(12'd2023, 4'd3, 5'd21);
		send_date(12'd2023, 4'd3, 5'd20);
		send_date(12'd2021, 4'd12, 5'd31);
		send_date(12'd2023, 4'd2, 5'd31);
		send_date(12'd2023, 4'd4, 5'd0);
		send_date(12'd2023, 4'd0, 5'd15);
		send_date(12'd2024, 4'd13, 5'd1);
		send_date(12'd2023, 4'd15, 5'd31);
		send_date(12'd1600, 4'd1, 5'd1);
		send_date(12'd1600, 4'd3, 5'd1);
		send_date(12'd1, 4'd6, 5'd10);
		send_date(12'd0, 4'd0, 5'd0);
		send_date(12'd4095, 4'd15, 5'd31);
		send_date(12'd2048, 4'd8, 5'd16);
		send_date(12'd1601, 4'd3, 5'd21);
		send_random_dates(PhaseItems);
		wait_drained();

		send_idle_pct = 76;
		recv_idle_pct = 10;
		send_random_dates(PhaseItems);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_token++;
		send_random_dates(PhaseItems);
		wait_drained();
		repeat (24) @(negedge clk);

		$display("sent %0d dates: corner dates, invalid days and months, years below 1601,",
			dates_sent);
		$display("three idle mixes and a long output stall; %0d results compared", compared);
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/g2j_pkg.sv
rtl/g2j_day_count.sv
rtl/gregorian_to_jalali_date_unit.sv
verif/jalali_date_checker.sv
verif/gregorian_to_jalali_date_unit_test.sv
